// File: rtl/nmps_pkg.sv
// Shared types and constants of the nearest map point search block.
package nmps_pkg;

   localparam int COORD_FIELD_W = 24;
   localparam int INDEX_FIELD_W = 10;
   localparam int LEN_W         = 11;
   localparam int DIST_W        = 25;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_ROOT,
      ST_OUT
   } nmps_state_type;

   typedef struct packed {
      logic                             cmd;
      logic [INDEX_FIELD_W-1:0]         point_index;
      logic signed [COORD_FIELD_W-1:0]  coord_x;
      logic signed [COORD_FIELD_W-1:0]  coord_y;
   } nmps_req_type;

   typedef struct packed {
      logic                     found;
      logic [INDEX_FIELD_W-1:0] nearest_index;
      logic [DIST_W-1:0]        nearest_distance;
   } nmps_rsp_type;

   typedef struct packed {
      logic mem_write;
      logic load_query;
      logic rd_en;
      logic root_start;
      logic load_rsp;
   } nmps_cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic root_done;
   } nmps_status_type;

endpackage

// File: rtl/nmps_ctrl.sv
// Controller: handshakes, length register, scan counter and query sequencing.
module nmps_ctrl #(
   parameter int MAP_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_cmd,
   output logic                              req_stall,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              csr_write_enable,
   input  logic [nmps_pkg::LEN_W-1:0]        csr_write_data,
   input  nmps_pkg::nmps_status_type         status,
   output nmps_pkg::nmps_cmd_type            cmd,
   output logic [$clog2(MAP_DEPTH)-1:0]      rd_addr
);
   import nmps_pkg::*;

   localparam int IDX_W = $clog2(MAP_DEPTH);
   localparam int CNT_W = $clog2(MAP_DEPTH + 1);

   nmps_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] map_length_ff, map_length_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] len_eff;

   // clamp the programmed length to the map depth
   assign len_eff = (32'(map_length_ff) > 32'(MAP_DEPTH)) ? CNT_W'(MAP_DEPTH)
                                                          : CNT_W'(map_length_ff);

   assign map_length_in = csr_write_enable ? csr_write_data : map_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         len_ff        <= '0;
         map_length_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         len_ff        <= len_in;
         map_length_ff <= map_length_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_cmd == CMD_QUERY) begin
                  cmd.load_query = 1'b1;
                  cnt_in         = '0;
                  len_in         = len_eff;
                  state_in       = ST_SCAN;
               end else begin
                  cmd.mem_write = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff == len_ff) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.rd_en = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            // wait for the last entry to pass the compare stage
            if (!status.pipe_busy) begin
               cmd.root_start = 1'b1;
               state_in       = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (status.root_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output word is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_addr   = cnt_ff[IDX_W-1:0];
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/nmps_sqrt.sv
// Iterative floor square root, one result bit per cycle.
module nmps_sqrt #(
   parameter int IN_W = 50
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [IN_W-1:0]          operand,
   output logic                     done,
   output logic [(IN_W+1)/2-1:0]    root
);

   localparam int ROOT_W = (IN_W + 1) / 2;
   localparam int RW     = ROOT_W + 2;
   localparam int SW     = $clog2(ROOT_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SW-1:0]         step_ff, step_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [2*ROOT_W-1:0]   n_ff, n_in;
   logic [RW-1:0]         shifted;
   logic [RW-1:0]         trial;
   logic [RW:0]           diff;

   assign shifted = {rem_ff[RW-3:0], n_ff[2*ROOT_W-1 -: 2]};
   assign trial   = {root_ff, 2'b01};
   assign diff    = {1'b0, shifted} - {1'b0, trial};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      n_in    = n_ff;
      if (start) begin
         n_in    = (2*ROOT_W)'(operand);
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = n_ff << 2;
         if (!diff[RW]) begin
            rem_in  = diff[RW-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         step_in = step_ff + SW'(1);
         if (step_ff == SW'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      n_ff    <= n_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: rtl/nmps_dpath.sv
// Datapath: point memory, distance pipeline, running minimum and result word.
module nmps_dpath #(
   parameter int MAP_DEPTH  = 1024,
   parameter int COORD_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nmps_pkg::nmps_req_type        req_data,
   input  nmps_pkg::nmps_cmd_type        cmd,
   input  logic [$clog2(MAP_DEPTH)-1:0]  rd_addr,
   output nmps_pkg::nmps_status_type     status,
   output nmps_pkg::nmps_rsp_type        rsp_data
);
   import nmps_pkg::*;

   localparam int IDX_W  = $clog2(MAP_DEPTH);
   localparam int MAG_W  = COORD_BITS + 1;
   localparam int PROD_W = 2 * MAG_W;
   localparam int AX_W   = (2*COORD_BITS + 1 > 64) ? 64 : 2*COORD_BITS + 1;
   localparam int SUM_W  = (2*COORD_BITS + 2 > 64) ? 64 : 2*COORD_BITS + 2;
   localparam int ROOT_W = (SUM_W + 1) / 2;
   localparam int RX_W   = ROOT_W + DIST_W;

   logic [2*COORD_BITS-1:0] map_mem [MAP_DEPTH];

   logic [COORD_BITS-1:0]   wr_x, wr_y;
   logic                    wr_in_range;
   logic [IDX_W-1:0]        wr_addr;

   logic [2*COORD_BITS-1:0] rd_word_ff;
   logic [COORD_BITS-1:0]   qx_ff, qx_in, qy_ff, qy_in;
   logic [COORD_BITS-1:0]   mx, my;

   logic                    v1_ff, v2_ff, v3_ff;
   logic [IDX_W-1:0]        idx1_ff, idx2_ff, idx3_ff;

   logic [MAG_W-1:0]        dx, dy;
   logic [MAG_W-1:0]        magx_ff, magx_in, magy_ff, magy_in;
   logic [PROD_W-1:0]       prodx, prody;
   logic [AX_W-1:0]         sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [SUM_W:0]          sum_full;
   logic [SUM_W-1:0]        sq;
   logic                    better;

   logic                    have_ff, have_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic [SUM_W-1:0]        best_sq_ff, best_sq_in;

   logic                    root_done;
   logic [ROOT_W-1:0]       root;
   logic [RX_W-1:0]         root_x;
   nmps_rsp_type            rsp_ff, rsp_in;

   // take the low COORD_BITS of each field as a signed coordinate
   assign wr_x = COORD_BITS'({{(32-COORD_FIELD_W){1'b0}}, req_data.coord_x});
   assign wr_y = COORD_BITS'({{(32-COORD_FIELD_W){1'b0}}, req_data.coord_y});

   assign wr_in_range = 32'(req_data.point_index) < 32'(MAP_DEPTH);
   assign wr_addr     = IDX_W'(req_data.point_index);

   always_ff @(posedge clock) begin
      if (cmd.mem_write && wr_in_range) begin
         map_mem[wr_addr] <= {wr_x, wr_y};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_word_ff <= map_mem[rd_addr];
      end
   end

   assign qx_in = cmd.load_query ? wr_x : qx_ff;
   assign qy_in = cmd.load_query ? wr_y : qy_ff;

   assign mx = rd_word_ff[2*COORD_BITS-1:COORD_BITS];
   assign my = rd_word_ff[COORD_BITS-1:0];

   // difference and magnitude
   assign dx      = {qx_ff[COORD_BITS-1], qx_ff} - {mx[COORD_BITS-1], mx};
   assign dy      = {qy_ff[COORD_BITS-1], qy_ff} - {my[COORD_BITS-1], my};
   assign magx_in = dx[MAG_W-1] ? -dx : dx;
   assign magy_in = dy[MAG_W-1] ? -dy : dy;

   // squares, saturated where they outgrow the 64-bit range
   assign prodx  = PROD_W'(magx_ff) * PROD_W'(magx_ff);
   assign prody  = PROD_W'(magy_ff) * PROD_W'(magy_ff);
   assign sqx_in = (|prodx[PROD_W-1:AX_W]) ? '1 : prodx[AX_W-1:0];
   assign sqy_in = (|prody[PROD_W-1:AX_W]) ? '1 : prody[AX_W-1:0];

   assign sum_full = (SUM_W+1)'(sqx_ff) + (SUM_W+1)'(sqy_ff);
   assign sq       = sum_full[SUM_W] ? '1 : sum_full[SUM_W-1:0];
   // strict less-than keeps the first minimum on a tie
   assign better   = !have_ff || (sq < best_sq_ff);

   always_comb begin
      have_in     = have_ff;
      best_idx_in = best_idx_ff;
      best_sq_in  = best_sq_ff;
      if (cmd.load_query) begin
         have_in     = 1'b0;
         best_idx_in = '0;
         best_sq_in  = '0;
      end else if (v3_ff && better) begin
         have_in     = 1'b1;
         best_idx_in = idx3_ff;
         best_sq_in  = sq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         v1_ff   <= cmd.rd_en;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         have_ff <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      idx1_ff     <= rd_addr;
      idx2_ff     <= idx1_ff;
      idx3_ff     <= idx2_ff;
      magx_ff     <= magx_in;
      magy_ff     <= magy_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      best_idx_ff <= best_idx_in;
      best_sq_ff  <= best_sq_in;
      rsp_ff      <= rsp_in;
   end

   nmps_sqrt #(
      .IN_W (SUM_W)
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.root_start),
      .operand (best_sq_ff),
      .done    (root_done),
      .root    (root)
   );

   assign root_x = RX_W'(root);

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.found            = have_ff;
         rsp_in.nearest_index    = INDEX_FIELD_W'(best_idx_ff);
         rsp_in.nearest_distance = (root_x > RX_W'(DIST_MAX)) ? DIST_MAX
                                                              : root_x[DIST_W-1:0];
      end
   end

   assign status   = '{pipe_busy: v1_ff | v2_ff | v3_ff, root_done: root_done};
   assign rsp_data = rsp_ff;

endmodule

// File: rtl/nearest_map_point_search.sv
// Top level of the nearest map point search block.
//
//   channel   dir  handshake                         word
//   req_      in   req_valid / req_stall             nmps_req_type
//   rsp_      out  rsp_valid / rsp_stall             nmps_rsp_type
//   csr_      in   csr_write_enable (no wait)        map_length, 11 bits
//
// A write word leaves the block idle, and the next word may follow at once.
// A query reads map_length entries, with map_length capped at MAP_DEPTH: one
// memory read a cycle through a four-stage distance pipeline, then the square-root
// unit, which resolves one result bit a cycle.
// The next word is taken in the cycle the result turns valid.
// Reset is synchronous; it clears the length register, the controller and the
// valid flags, and the map memory stays as it was.
// A stalled result is held in the output register while the next word is taken;
// a later result waits until that word has gone.
module nearest_map_point_search #(
   parameter int MAP_DEPTH  = 1024,
   parameter int COORD_BITS = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  nmps_pkg::nmps_req_type      req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output nmps_pkg::nmps_rsp_type      rsp_data,
   input  logic                        csr_write_enable,
   input  logic [nmps_pkg::LEN_W-1:0]  csr_write_data
);
   import nmps_pkg::*;

   localparam int IDX_W = $clog2(MAP_DEPTH);

   nmps_cmd_type     ctrl_cmd;
   nmps_status_type  ctrl_status;
   logic [IDX_W-1:0] rd_addr;

   nmps_ctrl #(
      .MAP_DEPTH (MAP_DEPTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_cmd          (req_data.cmd),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .status           (ctrl_status),
      .cmd              (ctrl_cmd),
      .rd_addr          (rd_addr)
   );

   nmps_dpath #(
      .MAP_DEPTH  (MAP_DEPTH),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (ctrl_cmd),
      .rd_addr  (rd_addr),
      .status   (ctrl_status),
      .rsp_data (rsp_data)
   );

endmodule

// File: rtl/nmps_checker.sv
// Port-level checker for the nearest map point search block, with its bind.
module nmps_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input nmps_pkg::nmps_req_type      req_data,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input nmps_pkg::nmps_rsp_type      rsp_data
);
   import nmps_pkg::*;

   // a stalled result word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
   else $error("result word changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
   else $error("result valid after reset");

   // an empty search reports index and distance of zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.nearest_index == '0 && rsp_data.nearest_distance == '0)
   else $error("empty search with non-zero fields");

   // a query occupies the block; a map write does not
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.cmd == CMD_QUERY |=> req_stall)
   else $error("word taken during a query");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.cmd == CMD_WRITE |=> !req_stall)
   else $error("stall after a map write");

endmodule

bind nearest_map_point_search nmps_checker u_nmps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_data         (req_data),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_data         (rsp_data)
);
